[design/midi_track_event_parser_macros.svh]
// Assertion macros for the parser's RTL.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTEP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mtep_pkg.sv]
package mtep_pkg;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_PROGRAM  = 3'd2,
    KIND_TEMPO    = 3'd3,
    KIND_END      = 3'd4,
    KIND_UNKNOWN  = 3'd5
  } kind_e;

  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_CONTROL  = 4'hB;
  localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] META_TEMPO      = 8'h51;
  localparam logic [7:0] META_END        = 8'h2F;
  localparam logic [7:0] TEMPO_LEN       = 8'h03;
  localparam logic [7:0] END_LEN         = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  channel;
    logic [3:0]  note_in_octave;
    logic [3:0]  octave;
    logic [7:0]  program_res;
    logic [23:0] tempo;
    logic [31:0] delta_ticks;
  } out_beat_t;

  typedef struct packed {
    logic [3:0] octave;
    logic [3:0] note;
  } key_split_t;

  // Division by twelve through a reciprocal multiply; exact for 7-bit keys.
  function automatic key_split_t split_key(input logic [6:0] key);
    logic [14:0] prod;
    logic [3:0]  quot;
    logic [6:0]  rem;
    key_split_t  res;
    prod = 15'(key) * 15'd171;
    quot = prod[14:11];
    rem  = key - (7'(quot) * 7'd12);
    res.note   = rem[3:0];
    res.octave = (quot == 4'd0) ? 4'd0 : quot - 4'd1;
    return res;
  endfunction

endpackage

[design/midi_track_event_parser.sv]
// Parser for the event stream of a MIDI file track, one byte per beat.
// The input channel carries a data byte and a track_start flag; a set flag
// restarts the parser so that the byte is read as the first delta time byte.
// The output channel carries one beat per reported event: note off, note on
// (note within the octave and octave), program change, tempo, end of track
// and unknown status, each with its channel and the delta time before it.
// Bytes that report nothing are absorbed without an output beat.
// A byte is held in an input register, decoded combinationally against the
// parser state and written to the output register, from which the receiver
// can take its result; one byte is accepted every cycle while the receiver
// does not stall.
// When the receiver stalls, the output register holds its beat and the
// input register holds the next byte, whether or not that byte gives a
// result, so the input stalls as well. After reset both registers are empty
// and the parser expects a delta time with all accumulators at zero.
`include "midi_track_event_parser_macros.svh"

module midi_track_event_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtep_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtep_pkg::out_beat_t out_data_o
);

  logic                item_valid;
  logic                take;
  logic                res_valid;
  logic                load;
  mtep_pkg::in_beat_t  item;
  mtep_pkg::out_beat_t res;

  assign take = item_valid && !(out_valid_o && out_stall_i);
  assign load = take && res_valid;

  mtep_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mtep_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtep_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `MTEP_ASSERT_SAME(a_load_free, clk_i, rst_ni, load, !(out_valid_o && out_stall_i), "load over held beat")
  `MTEP_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, load, out_valid_o && (out_data_o == $past(res)), "result lost")
  `MTEP_ASSERT_NEXT(a_item_held, clk_i, rst_ni, in_stall_o, item_valid && $stable(item), "staged byte lost")
  `MTEP_ASSERT_SAME(a_note_range, clk_i, rst_ni, out_valid_o, out_data_o.note_in_octave < 4'd12, "note out of range")

endmodule

[design/mtep_in_stage.sv]
module mtep_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mtep_pkg::in_beat_t  in_data_i,
  output logic                in_stall_o,
  input  logic                take_i,
  output logic                item_valid_o,
  output mtep_pkg::in_beat_t  item_o
);

  logic               valid_q;
  logic               valid_d;
  mtep_pkg::in_beat_t data_q;

  assign in_stall_o   = valid_q && !take_i;
  assign valid_d      = in_stall_o || in_valid_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

[design/mtep_decode.sv]
module mtep_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mtep_pkg::in_beat_t  item_i,
  output logic                res_valid_o,
  output mtep_pkg::out_beat_t res_o
);

  typedef enum logic [3:0] {
    PH_DELTA_FIRST = 4'd0,
    PH_DELTA_MORE  = 4'd1,
    PH_STATUS      = 4'd2,
    PH_NOTE_KEY    = 4'd3,
    PH_PROGRAM     = 4'd4,
    PH_META_TYPE   = 4'd5,
    PH_TEMPO_LEN   = 4'd6,
    PH_TEMPO_DATA  = 4'd7,
    PH_END_LEN     = 4'd8,
    PH_META_LEN    = 4'd9,
    PH_SKIP        = 4'd10
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [31:0] delta_q, delta_d, delta_c, delta_base;
  logic [3:0]  chan_q, chan_d, chan_c;
  logic [23:0] tempo_q, tempo_d, tempo_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [1:0]  count_q, count_d, count_c;
  logic [7:0]  b;
  mtep_pkg::key_split_t split;

  assign b     = item_i.data_byte;
  assign split = mtep_pkg::split_key(b[6:0]);

  always_comb begin
    if (item_i.track_start) begin
      phase_c = PH_DELTA_FIRST;
      delta_c = '0;
      chan_c  = '0;
      tempo_c = '0;
      skip_c  = '0;
      count_c = '0;
    end else begin
      phase_c = phase_q;
      delta_c = delta_q;
      chan_c  = chan_q;
      tempo_c = tempo_q;
      skip_c  = skip_q;
      count_c = count_q;
    end

    phase_d     = phase_c;
    delta_d     = delta_c;
    chan_d      = chan_c;
    tempo_d     = tempo_c;
    skip_d      = skip_c;
    count_d     = count_c;
    delta_base  = (phase_c == PH_DELTA_FIRST) ? 32'd0 : delta_c;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_c)
      PH_DELTA_FIRST, PH_DELTA_MORE: begin
        delta_d = {delta_base[24:0], 7'b0} + 32'(b[6:0]);
        phase_d = b[7] ? PH_DELTA_MORE : PH_STATUS;
      end
      PH_STATUS: begin
        chan_d  = b[3:0];
        phase_d = PH_DELTA_FIRST;
        if (b[7:4] == mtep_pkg::STATUS_NOTE_OFF) begin
          skip_d           = 32'd2;
          phase_d          = PH_SKIP;
          res_valid_o      = 1'b1;
          res_o.event_kind = mtep_pkg::KIND_NOTE_OFF;
        end else if (b[7:4] == mtep_pkg::STATUS_NOTE_ON) begin
          phase_d = PH_NOTE_KEY;
        end else if (b[7:4] == mtep_pkg::STATUS_PROGRAM) begin
          phase_d = PH_PROGRAM;
        end else if (b[7:4] == mtep_pkg::STATUS_CONTROL) begin
          skip_d  = 32'd2;
          phase_d = PH_SKIP;
        end else if (b == mtep_pkg::STATUS_META) begin
          phase_d = PH_META_TYPE;
        end else begin
          res_valid_o      = 1'b1;
          res_o.event_kind = mtep_pkg::KIND_UNKNOWN;
        end
      end
      PH_NOTE_KEY: begin
        skip_d               = 32'd1;
        phase_d              = PH_SKIP;
        res_valid_o          = 1'b1;
        res_o.event_kind     = mtep_pkg::KIND_NOTE_ON;
        res_o.note_in_octave = split.note;
        res_o.octave         = split.octave;
      end
      PH_PROGRAM: begin
        phase_d           = PH_DELTA_FIRST;
        res_valid_o       = 1'b1;
        res_o.event_kind  = mtep_pkg::KIND_PROGRAM;
        res_o.program_res = b;
      end
      PH_META_TYPE: begin
        if (b == mtep_pkg::META_TEMPO) begin
          phase_d = PH_TEMPO_LEN;
        end else if (b == mtep_pkg::META_END) begin
          phase_d = PH_END_LEN;
        end else begin
          skip_d  = '0;
          phase_d = PH_META_LEN;
        end
      end
      PH_TEMPO_LEN: begin
        if (b == mtep_pkg::TEMPO_LEN) begin
          tempo_d = '0;
          count_d = '0;
          phase_d = PH_TEMPO_DATA;
        end else begin
          phase_d = PH_DELTA_FIRST;
        end
      end
      PH_TEMPO_DATA: begin
        tempo_d = {tempo_c[15:0], b};
        if (count_c >= 2'd2) begin
          count_d          = '0;
          phase_d          = PH_DELTA_FIRST;
          res_valid_o      = 1'b1;
          res_o.event_kind = mtep_pkg::KIND_TEMPO;
          res_o.tempo      = {tempo_c[15:0], b};
        end else begin
          count_d = count_c + 2'd1;
        end
      end
      PH_END_LEN: begin
        phase_d = PH_DELTA_FIRST;
        if (b == mtep_pkg::END_LEN) begin
          res_valid_o      = 1'b1;
          res_o.event_kind = mtep_pkg::KIND_END;
        end
      end
      PH_META_LEN: begin
        skip_d = {skip_c[24:0], 7'b0} + 32'(b[6:0]);
        if (!b[7]) begin
          phase_d = (skip_d == 32'd0) ? PH_DELTA_FIRST : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_c != 32'd0) begin
          skip_d = skip_c - 32'd1;
        end
        if (skip_d == 32'd0) begin
          phase_d = PH_DELTA_FIRST;
        end
      end
      default: begin
        phase_d = PH_DELTA_FIRST;
      end
    endcase

    res_o.channel     = chan_d;
    res_o.delta_ticks = delta_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA_FIRST;
      delta_q <= '0;
      chan_q  <= '0;
      tempo_q <= '0;
      skip_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      delta_q <= delta_d;
      chan_q  <= chan_d;
      tempo_q <= tempo_d;
      skip_q  <= skip_d;
      count_q <= count_d;
    end
  end

endmodule

[design/mtep_out_stage.sv]
module mtep_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  mtep_pkg::out_beat_t res_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtep_pkg::out_beat_t out_data_o
);

  logic                valid_q;
  logic                valid_d;
  mtep_pkg::out_beat_t data_q;

  assign valid_d     = load_i || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

endmodule
